[hdl/mrx_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the MIPS R-type execute block: funct codes,
// multiply/divide operation codes and the structs between core and divider.
package mrx_pkg;

   localparam logic [5:0] OPC_SPECIAL = 6'b000000;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_SLLV    = 6'h04;
   localparam logic [5:0] FN_SRLV    = 6'h06;
   localparam logic [5:0] FN_SRAV    = 6'h07;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_MFHI    = 6'h10;
   localparam logic [5:0] FN_MTHI    = 6'h11;
   localparam logic [5:0] FN_MFLO    = 6'h12;
   localparam logic [5:0] FN_MTLO    = 6'h13;
   localparam logic [5:0] FN_MULT    = 6'h18;
   localparam logic [5:0] FN_MULTU   = 6'h19;
   localparam logic [5:0] FN_DIV     = 6'h1A;
   localparam logic [5:0] FN_DIVU    = 6'h1B;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2A;
   localparam logic [5:0] FN_SLTU    = 6'h2B;

   typedef enum logic [1:0] {
      MD_MULT  = 2'd0,
      MD_MULTU = 2'd1,
      MD_DIV   = 2'd2,
      MD_DIVU  = 2'd3
   } md_op_type;

   typedef struct packed {
      logic        start;
      md_op_type   op;
      logic [31:0] a;
      logic [31:0] b;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic        wen;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_rsp_type;

endpackage

[hdl/mrx_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the instruction and result transactions.
// Depends on nothing.
interface mrx_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;
   logic [31:0] pc_value;
   modport source (output valid, output instr_word, output pc_value, input ready);
   modport sink (input valid, input instr_word, input pc_value, output ready);
endinterface

interface mrx_rsp_if;
   logic        valid;
   logic        ready;
   logic        reg_write;
   logic [4:0]  dest_index;
   logic [31:0] dest_value;
   logic        jump_taken;
   logic [31:0] jump_target;
   logic [31:0] hi_value;
   logic [31:0] lo_value;
   logic        syscall_flag;
   logic        bad_instr;
   modport source (output valid, output reg_write, output dest_index, output dest_value,
                   output jump_taken, output jump_target, output hi_value,
                   output lo_value, output syscall_flag, output bad_instr, input ready);
   modport sink (input valid, input reg_write, input dest_index, input dest_value,
                 input jump_taken, input jump_target, input hi_value,
                 input lo_value, input syscall_flag, input bad_instr, output ready);
endinterface

[hdl/mrx_regfile.sv]
`timescale 1ns / 1ps
// General register file: 32 x 32-bit memory, two registered read ports, one
// write port. Per-entry valid bits make unwritten entries read as zero.
module mrx_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);
   logic [31:0] mem_ff [32];
   logic [31:0] valid_ff;
   logic [31:0] data_a_ff;
   logic [31:0] data_b_ff;
   logic        vld_a_ff;
   logic        vld_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      data_a_ff <= mem_ff[rd_addr_a];
      data_b_ff <= mem_ff[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_a_ff <= valid_ff[rd_addr_a];
         vld_b_ff <= valid_ff[rd_addr_b];
      end
   end

   assign rd_data_a = vld_a_ff ? data_a_ff : '0;
   assign rd_data_b = vld_b_ff ? data_b_ff : '0;
endmodule

[hdl/mrx_muldiv.sv]
`timescale 1ns / 1ps
// Multiply/divide unit: single-multiplier product registered at the start,
// restoring divider at one quotient bit per cycle. Uses mrx_pkg.
module mrx_muldiv (
   input  logic               clock,
   input  logic               reset,
   input  mrx_pkg::md_req_type md_req,
   output mrx_pkg::md_rsp_type md_rsp
);
   import mrx_pkg::*;

   typedef enum logic [3:0] {
      MS_IDLE = 4'b0001,
      MS_MUL  = 4'b0010,
      MS_DIV  = 4'b0100,
      MS_FIX  = 4'b1000
   } md_state_type;

   md_state_type state_ff, state_in;
   logic [63:0]  prod_ff;
   logic [31:0]  quo_ff;
   logic [31:0]  rem_ff;
   logic [31:0]  mb_ff;
   logic [4:0]   cnt_ff;
   logic         neg_q_ff;
   logic         neg_r_ff;
   logic         nz_ff;

   logic         sgn;
   logic [32:0]  a_ext;
   logic [32:0]  b_ext;
   logic [65:0]  prod_in;
   logic [32:0]  rem_sh;
   logic [32:0]  rem_diff;

   assign sgn   = (md_req.op == MD_MULT) || (md_req.op == MD_DIV);
   assign a_ext = {sgn & md_req.a[31], md_req.a};
   assign b_ext = {sgn & md_req.b[31], md_req.b};
   assign prod_in = 66'($signed(a_ext) * $signed(b_ext));

   assign rem_sh   = {rem_ff, quo_ff[31]};
   assign rem_diff = rem_sh - {1'b0, mb_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MS_IDLE: begin
            if (md_req.start) begin
               if (md_req.op == MD_MULT || md_req.op == MD_MULTU) begin
                  state_in = MS_MUL;
               end else begin
                  state_in = MS_DIV;
               end
            end
         end
         MS_MUL:  state_in = MS_IDLE;
         MS_DIV:  if (cnt_ff == 5'd31) state_in = MS_FIX;
         MS_FIX:  state_in = MS_IDLE;
         default: state_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == MS_IDLE && md_req.start) begin
         prod_ff  <= prod_in[63:0];
         quo_ff   <= (sgn && md_req.a[31]) ? (32'd0 - md_req.a) : md_req.a;
         mb_ff    <= (sgn && md_req.b[31]) ? (32'd0 - md_req.b) : md_req.b;
         rem_ff   <= '0;
         cnt_ff   <= '0;
         neg_q_ff <= sgn && (md_req.a[31] ^ md_req.b[31]);
         neg_r_ff <= sgn && md_req.a[31];
         nz_ff    <= md_req.b != 32'd0;
      end else if (state_ff == MS_DIV) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (!rem_diff[32]) begin
            rem_ff <= rem_diff[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_comb begin
      md_rsp.done = (state_ff == MS_MUL) || (state_ff == MS_FIX);
      md_rsp.wen  = (state_ff == MS_MUL) || nz_ff;
      if (state_ff == MS_MUL) begin
         md_rsp.hi = prod_ff[63:32];
         md_rsp.lo = prod_ff[31:0];
      end else begin
         md_rsp.hi = neg_r_ff ? (32'd0 - rem_ff) : rem_ff;
         md_rsp.lo = neg_q_ff ? (32'd0 - quo_ff) : quo_ff;
      end
   end
endmodule

[hdl/mips_rtype_execute_core.sv]
`timescale 1ns / 1ps
// Top level of the MIPS32 R-type execute block. Depends on mrx_pkg, mrx_if,
// mrx_regfile and mrx_muldiv.
//
// The block executes one R-type instruction per transaction against its own
// 32 x 32-bit register file and HI/LO pair, and returns one result
// transaction that reports the register write, any jump, HI/LO after the
// instruction and the syscall and bad-instruction flags. It works on one
// instruction at a time: req_ch.ready is high only while the core is idle.
// The register file is a synchronous memory with registered reads, read
// when the instruction is taken and written when its result is handed to
// the output register, so no two instructions ever overlap on it. Simple
// instructions go from execute straight to the result; mult, multu, div
// and divu wait for the multiply/divide unit and its restoring divider that
// retires one quotient bit per cycle. A new instruction is taken the cycle
// after the previous result was loaded, even while that result still waits
// for rsp_ch.ready. Writes to register zero are dropped, divide by zero
// leaves HI/LO alone, and no overflow trap is ever raised. After reset the
// register file, HI and LO read as zero with no clearing pass.
module mips_rtype_execute_core (
   input  logic   clock,
   input  logic   reset,
   mrx_req_if.sink   req_ch,
   mrx_rsp_if.source rsp_ch
);
   import mrx_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_MD   = 4'b0100,
      ST_DONE = 4'b1000
   } core_state_type;

   core_state_type state_ff, state_in;

   // Instruction captured with the transaction.
   logic [31:0] instr_ff;
   logic [31:0] pc_ff;

   // Architectural HI/LO.
   logic [31:0] hi_ff, lo_ff;

   // Result waiting to be committed.
   logic        p_wr_ff, p_jmp_ff, p_sys_ff, p_bad_ff;
   logic [4:0]  p_rd_ff;
   logic [31:0] p_val_ff, p_tgt_ff, p_hi_ff, p_lo_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic        o_wr_ff, o_jmp_ff, o_sys_ff, o_bad_ff;
   logic [4:0]  o_rd_ff;
   logic [31:0] o_val_ff, o_tgt_ff, o_hi_ff, o_lo_ff;

   logic        accept;
   logic        commit;
   logic [31:0] rs_val, rt_val;
   md_req_type  md_req;
   md_rsp_type  md_rsp;

   // Decode results.
   logic [5:0]  opc, fn;
   logic [4:0]  rd, sh;
   logic [31:0] val_in, tgt_in, hi_in, lo_in;
   logic        wr_in, jmp_in, sys_in, bad_in, md_in;
   md_op_type   md_op_in;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   mrx_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_a (req_ch.instr_word[25:21]),
      .rd_addr_b (req_ch.instr_word[20:16]),
      .rd_data_a (rs_val),
      .rd_data_b (rt_val),
      .wr_en     (commit && p_wr_ff),
      .wr_addr   (p_rd_ff),
      .wr_data   (p_val_ff)
   );

   assign md_req.start = (state_ff == ST_EXEC) && md_in;
   assign md_req.op    = md_op_in;
   assign md_req.a     = rs_val;
   assign md_req.b     = rt_val;

   mrx_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   assign opc = instr_ff[31:26];
   assign rd  = instr_ff[15:11];
   assign sh  = instr_ff[10:6];
   assign fn  = instr_ff[5:0];

   // Execute: operands arrive from the register file in this state.
   always_comb begin
      val_in   = '0;
      tgt_in   = '0;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      wr_in    = 1'b0;
      jmp_in   = 1'b0;
      sys_in   = 1'b0;
      bad_in   = 1'b0;
      md_in    = 1'b0;
      md_op_in = MD_MULT;
      if (opc != OPC_SPECIAL) begin
         bad_in = 1'b1;
      end else begin
         case (fn)
            FN_SLL:  begin val_in = rt_val << sh; wr_in = 1'b1; end
            FN_SRL:  begin val_in = rt_val >> sh; wr_in = 1'b1; end
            FN_SRA:  begin val_in = 32'($signed(rt_val) >>> sh); wr_in = 1'b1; end
            FN_SLLV: begin val_in = rt_val << rs_val[4:0]; wr_in = 1'b1; end
            FN_SRLV: begin val_in = rt_val >> rs_val[4:0]; wr_in = 1'b1; end
            FN_SRAV: begin
               val_in = 32'($signed(rt_val) >>> rs_val[4:0]);
               wr_in  = 1'b1;
            end
            FN_JR:   begin jmp_in = 1'b1; tgt_in = rs_val; end
            FN_JALR: begin
               jmp_in = 1'b1;
               tgt_in = rs_val;
               val_in = pc_ff;
               wr_in  = 1'b1;
            end
            FN_SYSCALL: sys_in = 1'b1;
            FN_MFHI: begin val_in = hi_ff; wr_in = 1'b1; end
            FN_MTHI: hi_in = rs_val;
            FN_MFLO: begin val_in = lo_ff; wr_in = 1'b1; end
            FN_MTLO: lo_in = rs_val;
            FN_MULT:  begin md_in = 1'b1; md_op_in = MD_MULT; end
            FN_MULTU: begin md_in = 1'b1; md_op_in = MD_MULTU; end
            FN_DIV:   begin md_in = 1'b1; md_op_in = MD_DIV; end
            FN_DIVU:  begin md_in = 1'b1; md_op_in = MD_DIVU; end
            FN_ADD, FN_ADDU: begin val_in = rs_val + rt_val; wr_in = 1'b1; end
            FN_SUB, FN_SUBU: begin val_in = rs_val - rt_val; wr_in = 1'b1; end
            FN_AND:  begin val_in = rs_val & rt_val; wr_in = 1'b1; end
            FN_OR:   begin val_in = rs_val | rt_val; wr_in = 1'b1; end
            FN_XOR:  begin val_in = rs_val ^ rt_val; wr_in = 1'b1; end
            FN_NOR:  begin val_in = ~(rs_val | rt_val); wr_in = 1'b1; end
            FN_SLT:  begin
               val_in = {31'd0, $signed(rs_val) < $signed(rt_val)};
               wr_in  = 1'b1;
            end
            FN_SLTU: begin val_in = {31'd0, rs_val < rt_val}; wr_in = 1'b1; end
            default: bad_in = 1'b1;
         endcase
      end
      // A write to register zero is reported as no write at all.
      if (rd == 5'd0) begin
         wr_in = 1'b0;
      end
      if (!wr_in) begin
         val_in = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: state_in = md_in ? ST_MD : ST_DONE;
         ST_MD:   if (md_rsp.done) state_in = ST_DONE;
         ST_DONE: if (commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hi_ff        <= '0;
         lo_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            hi_ff        <= p_hi_ff;
            lo_ff        <= p_lo_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         instr_ff <= req_ch.instr_word;
         pc_ff    <= req_ch.pc_value;
      end
      if (state_ff == ST_EXEC) begin
         p_wr_ff  <= wr_in;
         p_rd_ff  <= wr_in ? rd : 5'd0;
         p_val_ff <= val_in;
         p_jmp_ff <= jmp_in;
         p_tgt_ff <= tgt_in;
         p_sys_ff <= sys_in;
         p_bad_ff <= bad_in;
         p_hi_ff  <= hi_in;
         p_lo_ff  <= lo_in;
      end else if (state_ff == ST_MD && md_rsp.done && md_rsp.wen) begin
         p_hi_ff <= md_rsp.hi;
         p_lo_ff <= md_rsp.lo;
      end
      if (commit) begin
         o_wr_ff  <= p_wr_ff;
         o_rd_ff  <= p_rd_ff;
         o_val_ff <= p_val_ff;
         o_jmp_ff <= p_jmp_ff;
         o_tgt_ff <= p_tgt_ff;
         o_sys_ff <= p_sys_ff;
         o_bad_ff <= p_bad_ff;
         o_hi_ff  <= p_hi_ff;
         o_lo_ff  <= p_lo_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.reg_write    = o_wr_ff;
   assign rsp_ch.dest_index   = o_rd_ff;
   assign rsp_ch.dest_value   = o_val_ff;
   assign rsp_ch.jump_taken   = o_jmp_ff;
   assign rsp_ch.jump_target  = o_tgt_ff;
   assign rsp_ch.hi_value     = o_hi_ff;
   assign rsp_ch.lo_value     = o_lo_ff;
   assign rsp_ch.syscall_flag = o_sys_ff;
   assign rsp_ch.bad_instr    = o_bad_ff;
endmodule

[hdl/mrx_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for mips_rtype_execute_core and the bind that
// attaches them. Depends on mrx_if through the bound top level.
module mrx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_reg_write,
   input logic [4:0]  rsp_dest_index,
   input logic [31:0] rsp_dest_value,
   input logic        rsp_jump_taken,
   input logic [31:0] rsp_jump_target,
   input logic        rsp_syscall_flag,
   input logic        rsp_bad_instr
);
   // A waiting result transaction holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_value)
      && $stable(rsp_dest_index) && $stable(rsp_reg_write))
      else $error("result changed while stalled");

   // One instruction in flight: no acceptance right after another.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("instruction accepted while busy");

   // A register write never targets register zero.
   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_write |-> rsp_dest_index != 5'd0)
      else $error("write to register zero reported");

   // A bad instruction has no other effect.
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_instr |-> !rsp_reg_write && !rsp_jump_taken
      && !rsp_syscall_flag)
      else $error("bad instruction had side effects");

   // Unused result fields read as zero.
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reg_write || (rsp_dest_value == 32'd0 && rsp_dest_index == 5'd0))
      && (rsp_jump_taken || rsp_jump_target == 32'd0))
      else $error("unused result fields not zero");
endmodule

bind mips_rtype_execute_core mrx_checker u_mrx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_reg_write    (rsp_ch.reg_write),
   .rsp_dest_index   (rsp_ch.dest_index),
   .rsp_dest_value   (rsp_ch.dest_value),
   .rsp_jump_taken   (rsp_ch.jump_taken),
   .rsp_jump_target  (rsp_ch.jump_target),
   .rsp_syscall_flag (rsp_ch.syscall_flag),
   .rsp_bad_instr    (rsp_ch.bad_instr)
);
